// ===== rtl/core/imufd_pkg.sv =====
// imufd_pkg: shared constants and types for the imu frame decoder
// depends on nothing; used by the interfaces, the frame assembler and the top level
`timescale 1ns / 1ps

package imufd_pkg;

	// frame layout
	localparam logic [7:0] HDR_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_ACCEL = 8'h51;
	localparam logic [7:0] TYPE_RATE  = 8'h52;
	localparam logic [7:0] TYPE_ANGLE = 8'h53;
	localparam logic [3:0] POS_HUNT   = 4'd0;
	localparam logic [3:0] POS_TYPE   = 4'd1;
	localparam logic [3:0] POS_AXES_END = 4'd7;
	localparam logic [3:0] SUM_POS    = 4'd10;

	localparam int NUM_AXES  = 3;
	localparam int RAW_W     = 16;
	localparam int SCALE_W   = 24;
	localparam int AXIS_W    = 32;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SCALE = 2'd2;

	localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = 24'd80282;
	localparam logic [SCALE_W-1:0] RATE_SCALE_RST  = 24'd1024000;
	localparam logic [SCALE_W-1:0] ANGLE_SCALE_RST = 24'd0;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_SUM  = 2'd1,
		ST_BAD_TYPE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		KIND_ACCEL = 2'd0,
		KIND_RATE  = 2'd1,
		KIND_ANGLE = 2'd2
	} kind_t;

	typedef logic [NUM_AXES-1:0][RAW_W-1:0] raw_axes_t;

	// what the assembler hands over when a frame closes
	typedef struct packed {
		logic       last;
		logic       sum_ok;
		logic [7:0] ftype;
		raw_axes_t  raw;
	} frame_t;

endpackage

// ===== rtl/core/imufd_if.sv =====
// imufd_if: valid/ready channel interfaces for stream bytes and decoded results
// depends on imufd_pkg for field widths
`timescale 1ns / 1ps

interface imufd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imufd_res_if;
	logic                                     valid;
	logic                                     ready;
	logic [1:0]                               status;
	logic [1:0]                               kind;
	logic signed [imufd_pkg::AXIS_W-1:0]      axis_x;
	logic signed [imufd_pkg::AXIS_W-1:0]      axis_y;
	logic signed [imufd_pkg::AXIS_W-1:0]      axis_z;

	modport source (output valid, output status, output kind,
		output axis_x, output axis_y, output axis_z, input ready);
	modport sink   (input valid, input status, input kind,
		input axis_x, input axis_y, input axis_z, output ready);
endinterface

// ===== rtl/core/imufd_assembler.sv =====
// imufd_assembler: header hunt, byte position, running sum and raw axis capture
// depends on imufd_pkg
`timescale 1ns / 1ps

module imufd_assembler (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          rx_byte,
	output imufd_pkg::frame_t   frame
);

	logic [3:0]            pos_q;
	logic [7:0]            sum_q;
	logic [7:0]            ftype_q;
	logic [7:0]            pend_q;
	imufd_pkg::raw_axes_t  raw_q;
	logic [1:0]            axis_idx;

	// odd positions 3, 5, 7 carry the high bytes of x, y, z
	assign axis_idx = 2'(pos_q[2:1] - 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= imufd_pkg::POS_HUNT;
			sum_q   <= '0;
			ftype_q <= '0;
			pend_q  <= '0;
			raw_q   <= '0;
		end else if (accept) begin
			if (pos_q == imufd_pkg::POS_HUNT) begin
				if (rx_byte == imufd_pkg::HDR_BYTE) begin
					sum_q <= rx_byte;
					pos_q <= imufd_pkg::POS_TYPE;
				end
			end else if (pos_q < imufd_pkg::SUM_POS) begin
				sum_q <= 8'(sum_q + rx_byte);
				if (pos_q == imufd_pkg::POS_TYPE) begin
					ftype_q <= rx_byte;
				end else if (pos_q <= imufd_pkg::POS_AXES_END) begin
					if (!pos_q[0]) begin
						pend_q <= rx_byte;
					end else begin
						raw_q[axis_idx] <= {rx_byte, pend_q};
					end
				end
				pos_q <= 4'(pos_q + 4'd1);
			end else begin
				pos_q <= imufd_pkg::POS_HUNT;
			end
		end
	end

	always_comb begin
		frame.last   = accept && (pos_q >= imufd_pkg::SUM_POS);
		frame.sum_ok = (rx_byte == sum_q);
		frame.ftype  = ftype_q;
		frame.raw    = raw_q;
	end

endmodule

// ===== rtl/core/imufd_scaler.sv =====
// imufd_scaler: one axis, signed 16-bit raw times unsigned Q0.24 scale, rounded to Q15.16
// depends on imufd_pkg
`timescale 1ns / 1ps

module imufd_scaler (
	input  logic [imufd_pkg::RAW_W-1:0]          raw,
	input  logic [imufd_pkg::SCALE_W-1:0]        scale,
	output logic signed [imufd_pkg::AXIS_W-1:0]  axis
);

	localparam int PROD_W = imufd_pkg::RAW_W + imufd_pkg::SCALE_W + 1;

	logic signed [imufd_pkg::RAW_W-1:0]   raw_s;
	logic signed [imufd_pkg::SCALE_W:0]   scale_s;
	logic signed [PROD_W-1:0]             prod;
	logic signed [PROD_W-1:0]             rounded;

	assign raw_s   = $signed(raw);
	assign scale_s = $signed({1'b0, scale});
	assign prod    = raw_s * scale_s;
	// round half up, then floor shift by eight
	assign rounded = prod + PROD_W'(128);
	assign axis    = $signed(rounded[imufd_pkg::AXIS_W+7:8]);

endmodule

// ===== rtl/core/imu_frame_decoder.sv =====
// imu_frame_decoder: top level of the 11-byte sensor frame decoder
// depends on imufd_pkg, imufd_if, imufd_assembler and imufd_scaler
`timescale 1ns / 1ps

// channel  dir  beat payload                          notes
// rx       in   rx_byte[7:0]                          one stream byte per beat
// result   out  status, kind, axis_x/y/z (Q15.16)     one beat per closed frame
// cfg      in   cfg_we, cfg_index[1:0], cfg_wdata[23:0]  write only, no handshake
//
// one byte beat is taken every cycle that rx ready is high; after its checksum
// byte a frame moves to the dispatch register, then multiply and output register
// reset clears the hunt state, the pipeline valids and loads the scale defaults
// a stalled result holds in the output register while the dispatch stage still
// takes one more frame end; rx ready drops only when both stages are full

module imu_frame_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	imufd_rx_if.sink                         rx,
	imufd_res_if.source                      result,
	input  logic                             cfg_we,
	input  logic [imufd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [imufd_pkg::SCALE_W-1:0]    cfg_wdata
);

	// configuration registers
	logic [imufd_pkg::SCALE_W-1:0] accel_scale_q;
	logic [imufd_pkg::SCALE_W-1:0] rate_scale_q;
	logic [imufd_pkg::SCALE_W-1:0] angle_scale_q;

	// frame assembly
	logic               rx_accept;
	imufd_pkg::frame_t  frame;

	// dispatch stage
	logic                           valid_s1;
	imufd_pkg::status_t             status_s1;
	imufd_pkg::kind_t               kind_s1;
	logic [imufd_pkg::SCALE_W-1:0]  scale_s1;
	imufd_pkg::raw_axes_t           raw_s1;

	imufd_pkg::status_t             status_d;
	imufd_pkg::kind_t               kind_d;
	logic [imufd_pkg::SCALE_W-1:0]  scale_d;

	// output stage
	logic                                    valid_s2;
	imufd_pkg::status_t                      status_s2;
	imufd_pkg::kind_t                        kind_s2;
	logic signed [imufd_pkg::AXIS_W-1:0]     axis_x_s2;
	logic signed [imufd_pkg::AXIS_W-1:0]     axis_y_s2;
	logic signed [imufd_pkg::AXIS_W-1:0]     axis_z_s2;
	logic signed [imufd_pkg::AXIS_W-1:0]     axis_x_d;
	logic signed [imufd_pkg::AXIS_W-1:0]     axis_y_d;
	logic signed [imufd_pkg::AXIS_W-1:0]     axis_z_d;

	logic adv_s2;
	logic adv_s1;

	// config writes, indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_scale_q <= imufd_pkg::ACCEL_SCALE_RST;
			rate_scale_q  <= imufd_pkg::RATE_SCALE_RST;
			angle_scale_q <= imufd_pkg::ANGLE_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				imufd_pkg::REG_ACCEL_SCALE: accel_scale_q <= cfg_wdata;
				imufd_pkg::REG_RATE_SCALE:  rate_scale_q  <= cfg_wdata;
				imufd_pkg::REG_ANGLE_SCALE: angle_scale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline flow: output register drains when empty or taken
	assign adv_s2    = !valid_s2 || result.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign rx.ready  = adv_s1;
	assign rx_accept = rx.valid && rx.ready;

	imufd_assembler u_assembler (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (rx_accept),
		.rx_byte (rx.rx_byte),
		.frame   (frame)
	);

	// checksum first, then type dispatch; a zero scale forces zero axes on errors
	always_comb begin
		status_d = imufd_pkg::ST_OK;
		kind_d   = imufd_pkg::KIND_ACCEL;
		scale_d  = '0;
		if (!frame.sum_ok) begin
			status_d = imufd_pkg::ST_BAD_SUM;
		end else begin
			unique case (frame.ftype)
				imufd_pkg::TYPE_ACCEL: begin
					kind_d  = imufd_pkg::KIND_ACCEL;
					scale_d = accel_scale_q;
				end
				imufd_pkg::TYPE_RATE: begin
					kind_d  = imufd_pkg::KIND_RATE;
					scale_d = rate_scale_q;
				end
				imufd_pkg::TYPE_ANGLE: begin
					kind_d  = imufd_pkg::KIND_ANGLE;
					scale_d = angle_scale_q;
				end
				default: begin
					status_d = imufd_pkg::ST_BAD_TYPE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= frame.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && frame.last) begin
			status_s1 <= status_d;
			kind_s1   <= kind_d;
			scale_s1  <= scale_d;
			raw_s1    <= frame.raw;
		end
	end

	// one multiplier per axis, registered straight into the output stage
	imufd_scaler u_scale_x (.raw(raw_s1[0]), .scale(scale_s1), .axis(axis_x_d));
	imufd_scaler u_scale_y (.raw(raw_s1[1]), .scale(scale_s1), .axis(axis_y_d));
	imufd_scaler u_scale_z (.raw(raw_s1[2]), .scale(scale_s1), .axis(axis_z_d));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			status_s2 <= status_s1;
			kind_s2   <= kind_s1;
			axis_x_s2 <= axis_x_d;
			axis_y_s2 <= axis_y_d;
			axis_z_s2 <= axis_z_d;
		end
	end

	assign result.valid  = valid_s2;
	assign result.status = status_s2;
	assign result.kind   = kind_s2;
	assign result.axis_x = axis_x_s2;
	assign result.axis_y = axis_y_s2;
	assign result.axis_z = axis_z_s2;

endmodule
